### sv/bba_pkg.sv
`default_nettype none
package bba_pkg;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BADLEN = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic start;
        logic kind;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic idle;
    } t_sts;
endpackage
`default_nettype wire

### sv/bba_if.sv
`default_nettype none
interface bba_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] request_length;
    logic [11:0] block_address;
    modport source(output valid, kind, request_length, block_address, input ready);
    modport sink(input valid, kind, request_length, block_address, output ready);
endinterface

interface bba_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] data_address;
    logic [3:0]  granted_level;
    modport source(output valid, status, data_address, granted_level, input ready);
    modport sink(input valid, status, data_address, granted_level, output ready);
endinterface
`default_nettype wire

### sv/bba_ctrl.sv
`default_nettype none
module bba_ctrl
    import bba_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    bba_in_if.sink   in_ch,
    bba_out_if.source out_ch,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;

    // A new item enters when the machine is idle, no result waits and the
    // datapath has finished its clearing pass.
    assign in_ch.ready  = (r_state == S_IDLE) && i_sts.idle;
    assign out_ch.valid = (r_state == S_OUT);
    assign o_cmd        = t_cmd'{start: in_ch.valid && in_ch.ready, kind: in_ch.kind};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (o_cmd.start) n_state = S_BUSY;
            S_BUSY: if (i_sts.done) n_state = S_OUT;
            S_OUT:  if (out_ch.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

### sv/bba_dp.sv
`default_nettype none
module bba_dp
    import bba_pkg::*;
#(
    parameter int POOL_LEVEL = 12,
    parameter int MIN_BLOCK_LEVEL = 3,
    parameter int HEADER_BYTES = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    input  wire  [15:0] i_len,
    input  wire  [11:0] i_addr,
    output t_sts        o_sts,
    output logic [1:0]  o_status,
    output logic [11:0] o_data_address,
    output logic [3:0]  o_granted_level
);
    localparam int NE = 1 << (POOL_LEVEL - MIN_BLOCK_LEVEL);
    localparam int SW = POOL_LEVEL - MIN_BLOCK_LEVEL;
    localparam int PW = POOL_LEVEL + 1;
    localparam logic [4:0] PL = 5'(POOL_LEVEL);
    localparam logic [4:0] ML = 5'(MIN_BLOCK_LEVEL);

    localparam logic [3:0] D_IDLE  = 4'd0;
    localparam logic [3:0] D_WREQ  = 4'd1;
    localparam logic [3:0] D_WCHK  = 4'd2;
    localparam logic [3:0] D_SPLIT = 4'd3;
    localparam logic [3:0] D_SPW   = 4'd4;
    localparam logic [3:0] D_FREQ  = 4'd5;
    localparam logic [3:0] D_FCHK  = 4'd6;
    localparam logic [3:0] D_MREQ  = 4'd7;
    localparam logic [3:0] D_MCHK  = 4'd8;
    localparam logic [3:0] D_DONE  = 4'd9;
    localparam logic [3:0] D_CLR   = 4'd10;

    // Header store: taken bit and level, one word per granule.
    logic [4:0] mem [NE];
    logic [4:0] r_rd;
    logic [SW-1:0] rd_a, wr_a;
    logic [4:0] wr_d;
    logic wr_en;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_a] <= wr_d;
        r_rd <= mem[rd_a];
    end

    logic [3:0]  r_st;
    logic        r_kind;
    logic [4:0]  r_want, r_lv, r_blv;
    logic [PW-1:0] r_pos, r_bpos, r_head;
    logic        r_found;
    logic [1:0]  r_status;
    logic [SW:0] r_clr;

    logic [4:0] rd_lv;
    always_comb begin
        rd_lv = {1'b0, r_rd[3:0]};
        if (rd_lv < ML) rd_lv = ML;
        if (rd_lv > PL) rd_lv = PL;
    end
    wire rd_tk = r_rd[4];

    // Needed level of the request.
    logic [16:0] total;
    logic [4:0]  need;
    always_comb begin
        total = {1'b0, i_len} + 17'(HEADER_BYTES);
        need = 5'd17;
        for (int k = 16; k >= 0; k--) begin
            if ((17'd1 << k) >= total) need = 5'(k);
        end
        if (need < ML) need = ML;
    end

    wire [PW-1:0] step = PW'(1) << rd_lv;
    wire [PW-1:0] nxt  = r_pos + step;
    wire [PW-1:0] bud  = r_pos ^ (PW'(1) << r_lv);
    wire [PW-1:0] half = r_bpos | (PW'(1) << (r_blv - 5'd1));
    wire [PW-1:0] mpos = r_pos & ~((PW'(1) << (r_lv + 5'd1)) - PW'(1));

    always_comb begin
        rd_a  = r_pos[MIN_BLOCK_LEVEL +: SW];
        wr_en = 1'b0;
        wr_a  = r_pos[MIN_BLOCK_LEVEL +: SW];
        wr_d  = '0;
        case (r_st)
            D_MREQ: rd_a = bud[MIN_BLOCK_LEVEL +: SW];
            D_CLR: begin
                wr_en = 1'b1;
                wr_a  = r_clr[SW-1:0];
                wr_d  = (r_clr == '0) ? {1'b0, PL[3:0]} : 5'd0;
            end
            D_SPLIT: begin
                wr_en = 1'b1;
                wr_a  = half[MIN_BLOCK_LEVEL +: SW];
                wr_d  = {1'b0, 4'(r_blv - 5'd1)};
            end
            D_SPW: begin
                wr_en = 1'b1;
                wr_a  = r_bpos[MIN_BLOCK_LEVEL +: SW];
                wr_d  = (r_blv == r_want) ? {1'b1, r_blv[3:0]} : {1'b0, r_blv[3:0]};
            end
            D_FCHK: begin
                wr_en = (r_pos == r_head) && rd_tk;
                wr_d  = {1'b0, rd_lv[3:0]};
            end
            D_MCHK: begin
                wr_en = !rd_tk && (rd_lv == r_lv) && (r_lv < PL);
                wr_a  = mpos[MIN_BLOCK_LEVEL +: SW];
                wr_d  = {1'b0, 4'(r_lv + 5'd1)};
            end
            default: ;
        endcase
    end

    assign o_sts = t_sts'{done: (r_st == D_DONE), idle: (r_st == D_IDLE)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= D_CLR;
            r_clr <= '0;
        end else begin
            case (r_st)
                D_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (SW+1)'(NE - 1)) r_st <= D_IDLE;
                end
                D_IDLE: if (i_cmd.start) begin
                    r_kind   <= i_cmd.kind;
                    r_pos    <= '0;
                    r_found  <= 1'b0;
                    r_status <= ST_OK;
                    r_want   <= need;
                    r_blv    <= '0;
                    r_bpos   <= '0;
                    r_head   <= PW'({1'b0, i_addr} - 13'(HEADER_BYTES));
                    if (i_cmd.kind == KIND_FREE) begin
                        r_st <= (i_addr < 12'(HEADER_BYTES) ||
                                 (PW'({1'b0, i_addr} - 13'(HEADER_BYTES)) >>
                                  POOL_LEVEL) != '0) ? D_DONE : D_FREQ;
                    end else if (i_len == '0 || need > PL) begin
                        r_status <= ST_BADLEN;
                        r_st <= D_DONE;
                    end else begin
                        r_st <= D_WREQ;
                    end
                end
                D_WREQ: r_st <= D_WCHK;
                D_WCHK: begin
                    if (!rd_tk && rd_lv >= r_want && (!r_found || rd_lv < r_blv)) begin
                        r_found <= 1'b1;
                        r_bpos  <= r_pos;
                        r_blv   <= rd_lv;
                    end
                    r_pos <= nxt;
                    if (nxt[POOL_LEVEL]) begin
                        if (!r_found && !(!rd_tk && rd_lv >= r_want)) begin
                            r_status <= ST_NOFIT;
                            r_st <= D_DONE;
                        end else begin
                            r_st <= D_SPW;
                        end
                    end else begin
                        r_st <= D_WREQ;
                    end
                end
                D_SPW: begin
                    if (r_blv == r_want) r_st <= D_DONE;
                    else r_st <= D_SPLIT;
                end
                D_SPLIT: begin
                    r_blv <= r_blv - 5'd1;
                    r_st  <= D_SPW;
                end
                D_FREQ: r_st <= D_FCHK;
                D_FCHK: begin
                    if (r_pos == r_head || nxt > r_head) begin
                        r_lv  <= rd_lv;
                        r_st  <= (r_pos == r_head && rd_tk) ? D_MREQ : D_DONE;
                    end else begin
                        r_pos <= nxt;
                        r_st  <= D_FREQ;
                    end
                end
                D_MREQ: r_st <= (r_lv < PL) ? D_MCHK : D_DONE;
                D_MCHK: begin
                    if (wr_en) begin
                        r_pos <= mpos;
                        r_lv  <= r_lv + 5'd1;
                        r_st  <= D_MREQ;
                    end else begin
                        r_st <= D_DONE;
                    end
                end
                D_DONE: r_st <= D_IDLE;
                default: r_st <= D_IDLE;
            endcase
        end
    end

    // Result registers are loaded when an item completes and hold until the next one completes.
    always_ff @(posedge i_clk) begin
        if (r_st == D_DONE) begin
            o_status <= r_status;
            if (r_kind == KIND_ALLOC && r_status == ST_OK) begin
                o_data_address  <= 12'(r_bpos + PW'(HEADER_BYTES));
                o_granted_level <= r_blv[3:0];
            end else begin
                o_data_address  <= '0;
                o_granted_level <= '0;
            end
        end
    end
endmodule
`default_nettype wire

### sv/buddy_block_allocator_top.sv
`default_nettype none
// Channel   Dir  Payload
// in_ch     in   kind, request_length, block_address
// out_ch    out  status, data_address, granted_level
// One item at a time. An allocate walks the block headers and then splits
// the found block; a free walks the headers up to the freed block and then
// merges level by level, all through the single header memory.
// After reset a clearing pass over all 2^(POOL_LEVEL-MIN_BLOCK_LEVEL) headers (512)
// runs before the first item is taken. A stalled result holds the block.
module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int POOL_LEVEL = 12,
    parameter int MIN_BLOCK_LEVEL = 3,
    parameter int HEADER_BYTES = 4
) (
    input wire i_clk,
    input wire i_rst_n,
    bba_in_if.sink    in_ch,
    bba_out_if.source out_ch
);
    t_cmd cmd;
    t_sts sts;

    // The controller owns the handshakes; the datapath walks the headers.
    bba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch), .out_ch(out_ch),
        .i_sts(sts), .o_cmd(cmd)
    );

    bba_dp #(
        .POOL_LEVEL(POOL_LEVEL), .MIN_BLOCK_LEVEL(MIN_BLOCK_LEVEL),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .i_len(in_ch.request_length), .i_addr(in_ch.block_address),
        .o_sts(sts), .o_status(out_ch.status),
        .o_data_address(out_ch.data_address),
        .o_granted_level(out_ch.granted_level)
    );
endmodule
`default_nettype wire
